// ===== design/disf_pkg.sv =====
// Shared constants and tables of powers of ten and five for the decimal shred fit block.
`default_nettype none
package disf_pkg;

    localparam int DEF_MAX_DIGITS = 38;
    // Table entries 0 to 38; powers from 39 up no longer fit in 128 bits.
    localparam int TAB_N = 39;
    localparam int TAB_W = 6;

    typedef logic [TAB_N-1:0][127:0] tab_t;

    typedef enum logic [2:0] {
        KIND_INT8  = 3'd0,
        KIND_INT16 = 3'd1,
        KIND_INT32 = 3'd2,
        KIND_INT64 = 3'd3,
        KIND_DEC   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_KIND  = 2'd0,
        REG_PREC  = 2'd1,
        REG_SCALE = 2'd2
    } reg_idx_t;

    // Multiplicative inverse of five modulo two to the 128th.
    localparam logic [127:0] INV5 = 128'hCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCCD;

    function automatic tab_t build_pow10();
        tab_t t;
        logic [127:0] v;
        v = 128'd1;
        for (int k = 0; k < TAB_N; k++) begin
            t[k] = v;
            v = v * 128'd10;
        end
        return t;
    endfunction

    function automatic tab_t build_inv5();
        tab_t t;
        logic [127:0] v;
        v = 128'd1;
        for (int k = 0; k < TAB_N; k++) begin
            t[k] = v;
            v = v * INV5;
        end
        return t;
    endfunction

    function automatic tab_t build_lim5();
        tab_t t;
        logic [127:0] v;
        v = '1;
        for (int k = 0; k < TAB_N; k++) begin
            t[k] = v;
            v = v / 128'd5;
        end
        return t;
    endfunction

    localparam tab_t POW10 = build_pow10();
    localparam tab_t INV5_POW = build_inv5();
    localparam tab_t LIM5_POW = build_lim5();

endpackage
`default_nettype wire

// ===== design/decimal_integer_shred_fit.sv =====
// Top level of the decimal and integer typed-column fit check.
// Each request carries an integer or a 128-bit decimal; the block tells whether it fits the
// configured int8/16/32/64 or decimal(precision, scale) column exactly and gives the value at
// the target scale. A five-stage pipeline takes one request per cycle while the output is not
// stalled: magnitude and rescale direction, shift and table lookup, 32x32 partial products
// of the 128-bit rescale multiply, their sum, and the range checks. Rescaling down uses
// exact division by a power of five through its modular inverse. There is no clearing pass
// after reset.
`default_nettype none
module decimal_integer_shred_fit
    import disf_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // unscaled_low [63:0], unscaled_high [127:64], source_scale [133:128], zero pad
    input  wire logic [135:0] s_tdata,
    // source_kind
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_low [63:0], result_high [127:64]
    output logic [127:0]      m_tdata,
    // shredded
    output logic              m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [5:0]   cfg_data
);

    logic [2:0] kind_reg;
    logic [5:0] prec_reg;
    logic [5:0] tscale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= KIND_INT64;
            prec_reg   <= 6'd38;
            tscale_reg <= 6'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KIND:  kind_reg   <= cfg_data[2:0];
                REG_PREC:  prec_reg   <= cfg_data;
                REG_SCALE: tscale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: sign, magnitude and rescale direction.
    logic         is_dec;
    logic [5:0]   sscale;
    logic [63:0]  in_lo;
    logic [63:0]  in_hi;
    logic [127:0] raw;
    logic         neg_next;
    logic [127:0] mag_next;
    logic         up_next;
    logic [5:0]   p_next;
    logic         kind_ok_next;

    always_comb begin
        is_dec = s_tuser;
        sscale = s_tdata[133:128];
        in_lo  = s_tdata[63:0];
        in_hi  = is_dec ? s_tdata[127:64] : {64{in_lo[63]}};
        raw    = {in_hi, in_lo};
        neg_next = in_hi[63];
        mag_next = neg_next ? (~raw + 128'd1) : raw;
        kind_ok_next = (kind_reg <= KIND_DEC);
        up_next = 1'b0;
        p_next  = 6'd0;
        if (kind_reg == KIND_DEC) begin
            if (!is_dec) begin
                up_next = 1'b1;
                p_next  = tscale_reg;
            end else if (tscale_reg >= sscale) begin
                up_next = 1'b1;
                p_next  = tscale_reg - sscale;
            end else begin
                p_next = sscale - tscale_reg;
            end
        end else if (is_dec) begin
            p_next = sscale;
        end
    end

    logic         neg1_reg, up1_reg, kok1_reg;
    logic [127:0] mag1_reg;
    logic [5:0]   p1_reg;
    logic [2:0]   kind1_reg;
    logic [5:0]   prec1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            neg1_reg  <= neg_next;
            mag1_reg  <= mag_next;
            up1_reg   <= up_next;
            p1_reg    <= p_next;
            kok1_reg  <= kind_ok_next;
            kind1_reg <= kind_reg;
            prec1_reg <= prec_reg;
        end
    end

    // Stage 2: precondition, multiplier operand and table constant.
    logic             m_zero;
    logic             p_in_tab;
    logic [TAB_W-1:0] pidx;
    logic [TAB_W-1:0] up_idx;
    logic [127:0]     low_mask;
    logic             cond_next;
    logic [127:0]     x_next;
    logic [127:0]     k_next;

    always_comb begin
        m_zero   = (mag1_reg == 128'd0);
        p_in_tab = (p1_reg < TAB_W'(TAB_N));
        pidx     = p_in_tab ? p1_reg : '0;
        up_idx   = (p1_reg < TAB_W'(MAX_DIGITS)) ? (TAB_W'(MAX_DIGITS) - p1_reg) : '0;
        low_mask = (128'd1 << p1_reg) - 128'd1;
        if (up1_reg) begin
            cond_next = (p1_reg == 6'd0) || m_zero ||
                        ((p1_reg < TAB_W'(MAX_DIGITS)) && (mag1_reg < POW10[up_idx]));
            x_next = mag1_reg;
            k_next = POW10[pidx];
        end else begin
            // Divisible by ten to the p: the power of two shows in the low bits, the
            // power of five is checked later on the exact-division product.
            cond_next = p_in_tab ? ((mag1_reg & low_mask) == 128'd0) : m_zero;
            x_next    = p_in_tab ? (mag1_reg >> p1_reg) : 128'd0;
            k_next    = INV5_POW[pidx];
        end
        cond_next = cond_next && kok1_reg;
    end

    logic         neg2_reg, up2_reg, ok2_reg;
    logic [127:0] x2_reg, k2_reg;
    logic [5:0]   pidx2_reg;
    logic [2:0]   kind2_reg;
    logic [5:0]   prec2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            neg2_reg  <= neg1_reg;
            up2_reg   <= up1_reg;
            ok2_reg   <= cond_next;
            x2_reg    <= x_next;
            k2_reg    <= k_next;
            pidx2_reg <= pidx;
            kind2_reg <= kind1_reg;
            prec2_reg <= prec1_reg;
        end
    end

    // Stage 3: partial products of the low 128 bits of x times k.
    logic [63:0]  pp_reg [4][4];
    logic         neg3_reg, up3_reg, ok3_reg;
    logic [5:0]   pidx3_reg;
    logic [2:0]   kind3_reg;
    logic [5:0]   prec3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (i + j < 4) begin
                        pp_reg[i][j] <= 64'(x2_reg[32*i +: 32]) * 64'(k2_reg[32*j +: 32]);
                    end
                end
            end
            neg3_reg  <= neg2_reg;
            up3_reg   <= up2_reg;
            ok3_reg   <= ok2_reg;
            pidx3_reg <= pidx2_reg;
            kind3_reg <= kind2_reg;
            prec3_reg <= prec2_reg;
        end
    end

    // Stage 4: sum of partial products.
    logic [127:0] q_next;

    always_comb begin
        q_next = 128'd0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (i + j < 4) begin
                    q_next = q_next + ({64'd0, pp_reg[i][j]} << (32 * (i + j)));
                end
            end
        end
    end

    logic [127:0] q4_reg;
    logic         neg4_reg, up4_reg, ok4_reg;
    logic [5:0]   pidx4_reg;
    logic [2:0]   kind4_reg;
    logic [5:0]   prec4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            q4_reg    <= q_next;
            neg4_reg  <= neg3_reg;
            up4_reg   <= up3_reg;
            ok4_reg   <= ok3_reg;
            pidx4_reg <= pidx3_reg;
            kind4_reg <= kind3_reg;
            prec4_reg <= prec3_reg;
        end
    end

    // Stage 5: exactness, range checks and sign.
    logic         exact;
    logic         fit;
    logic [127:0] int_lim;
    logic         ok_final;
    logic [127:0] res_next;

    always_comb begin
        exact   = up4_reg || (q4_reg <= LIM5_POW[pidx4_reg]);
        int_lim = 128'd1 << ((8'd8 << kind4_reg[1:0]) - 8'd1);
        if (kind4_reg == KIND_DEC) begin
            if (prec4_reg == 6'd0) begin
                fit = 1'b0;
            end else if (prec4_reg >= TAB_W'(TAB_N)) begin
                fit = 1'b1;
            end else begin
                fit = q4_reg < POW10[prec4_reg];
            end
        end else begin
            fit = neg4_reg ? (q4_reg <= int_lim) : (q4_reg < int_lim);
        end
        ok_final = ok4_reg && exact && fit;
        res_next = ok_final ? (neg4_reg ? (~q4_reg + 128'd1) : q4_reg) : 128'd0;
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            m_tdata <= res_next;
            m_tuser <= ok_final;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_decimal_integer_shred_fit.sv =====
// Self-checking testbench for the decimal and integer typed-column fit check.
`default_nettype none
module tb_decimal_integer_shred_fit;
    import disf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic         fits;
        logic [127:0] value;
    } fit_result_t;

    int mismatches = 0;

    function automatic void report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endfunction

    // Predicts the fit of every accepted request and checks results in order.
    class fit_scoreboard;
        logic [2:0] kind;
        logic [5:0] prec;
        logic [5:0] scale;
        fit_result_t pending[$];
        int errors;

        function new();
            kind = KIND_INT64;
            prec = 6'd38;
            scale = 6'd0;
            errors = 0;
        endfunction

        function automatic int count_digits(logic [127:0] m);
            int d;
            d = 1;
            m = m / 128'd10;
            while (m != 0) begin
                d++;
                m = m / 128'd10;
            end
            return d;
        endfunction

        // Raising the scale refuses a step once the value has MAX_DIGITS digits.
        function automatic bit raise(ref logic [127:0] m, input int steps);
            for (int i = 0; i < steps; i++) begin
                if (count_digits(m) >= DEF_MAX_DIGITS) return 0;
                m = m * 128'd10;
            end
            return 1;
        endfunction

        function automatic bit lower(ref logic [127:0] m, input int steps);
            for (int i = 0; i < steps; i++) begin
                if (m % 128'd10 != 0) return 0;
                m = m / 128'd10;
            end
            return 1;
        endfunction

        function automatic bit fits_int(logic [127:0] m, bit neg, int bits);
            logic [127:0] lim;
            if (m[127:64] != 0) return 0;
            lim = 128'd1 << (bits - 1);
            return neg ? (m <= lim) : (m < lim);
        endfunction

        function automatic void note_request(bit is_dec, logic [127:0] v, logic [5:0] sscale);
            fit_result_t r;
            logic [127:0] m;
            bit neg, ok;
            int bits;
            ok = 0;
            if (!is_dec) v = {{64{v[63]}}, v[63:0]};
            neg = v[127];
            m = neg ? -v : v;
            bits = 8 << kind[1:0];
            if (!is_dec) begin
                if (kind < KIND_DEC) ok = fits_int(m, neg, bits);
                else if (kind == KIND_DEC)
                    ok = raise(m, scale) && count_digits(m) <= prec;
            end else if (kind == KIND_DEC) begin
                if (count_digits(m) <= prec && sscale == scale) ok = 1;
                else if (scale >= sscale)
                    ok = raise(m, scale - sscale) && count_digits(m) <= prec;
                else ok = lower(m, sscale - scale) && count_digits(m) <= prec;
            end else if (kind < KIND_DEC) begin
                ok = lower(m, sscale) && fits_int(m, neg, bits);
            end
            r.fits = ok;
            r.value = ok ? (neg ? -m : m) : 128'd0;
            pending.push_back(r);
        endfunction

        function automatic void check_result(logic fits, logic [127:0] value);
            fit_result_t e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %0b %h", fits, value));
                return;
            end
            e = pending.pop_front();
            if (fits !== e.fits)
                report_mismatch($sformatf("shredded %0b, predicted %0b", fits, e.fits));
            if (value[63:0] !== e.value[63:0])
                report_mismatch($sformatf("result_low %h, predicted %h",
                                          value[63:0], e.value[63:0]));
            if (value[127:64] !== e.value[127:64])
                report_mismatch($sformatf("result_high %h, predicted %h",
                                          value[127:64], e.value[127:64]));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [5:0]   cfg_data;

    fit_scoreboard fit_sb;

    decimal_integer_shred_fit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // Sink with random stalls; results are checked at the accepting edge.
    initial begin
        int gap;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        m_tready <= 1;
        forever begin
            @(posedge aclk iff (m_tvalid && m_tready));
            fit_sb.check_result(m_tuser, m_tdata);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [5:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            REG_KIND:  fit_sb.kind = val[2:0];
            REG_PREC:  fit_sb.prec = val;
            default:   fit_sb.scale = val;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (fit_sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // The request stays valid after acceptance until the next gap or drain lowers it.
    task automatic send_request(bit is_dec, logic [127:0] v, logic [5:0] sscale, bit bursty);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= is_dec;
        s_tdata <= {2'b00, sscale, v};
        @(posedge aclk iff s_tready);
        fit_sb.note_request(is_dec, v, sscale);
    endtask

    function automatic logic [127:0] pick_value();
        logic [127:0] v;
        int d;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom, $urandom, $urandom};
            1: v = 128'($urandom_range(0, 300));
            2: begin
                d = $urandom_range(0, 38);
                v = POW10[d] * 128'($urandom_range(1, 9));
            end
            3: v = 128'({$urandom, $urandom});
            4: v = 128'(1) << $urandom_range(0, 127);
            default: v = POW10[$urandom_range(0, 38)] - 128'd1;
        endcase
        if ($urandom_range(0, 1)) v = -v;
        if ($urandom_range(0, 15) == 0) v = v - 128'd1;
        return v;
    endfunction

    logic [127:0] edge_vals[12];

    initial begin
        int n;
        fit_sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        cfg_we = 0;
        cfg_index = REG_KIND;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        edge_vals = '{128'd0, 128'd127, -128'd128, 128'd128, -128'd129, 128'd32767,
                      {1'b0, {127{1'b1}}}, {1'b1, 127'd0}, 128'h7FFFFFFFFFFFFFFF,
                      128'hFFFFFFFFFFFFFFFF8000000000000000, POW10[37], POW10[38] - 1};
        // Directed: extremes under each integer kind, decimal and the unknown kinds.
        for (int k = 0; k < 8; k++) begin
            drain();
            write_reg(REG_KIND, 6'(k));
            for (int i = 0; i < 3; i++)
                send_request(i[0], edge_vals[(k * 3 + i) % 12], 6'(i), 0);
        end
        drain();
        write_reg(REG_KIND, 6'(KIND_DEC));
        write_reg(REG_PREC, 6'd0);
        write_reg(REG_SCALE, 6'd63);
        send_request(1, 128'd0, 6'd0, 0);
        send_request(0, 128'd5, 6'd0, 0);
        drain();
        write_reg(REG_PREC, 6'd63);
        send_request(1, 128'd7, 6'd63, 0);
        send_request(1, 128'd7000, 6'd63, 0);
        drain();

        // Random phases across many register settings.
        for (int ph = 0; ph < 31; ph++) begin
            drain();
            if (ph == 0) write_reg(REG_KIND, 6'(KIND_DEC));
            else write_reg(REG_KIND, ($urandom_range(0, 9) == 0) ? 6'($urandom_range(5, 7))
                                     : 6'($urandom_range(0, 4)));
            write_reg(REG_PREC, (ph == 1) ? 6'd1 : (ph == 2) ? 6'd38
                                : 6'($urandom_range(0, 63)));
            write_reg(REG_SCALE, (ph == 3) ? 6'd38 : ($urandom_range(0, 7) == 0)
                                 ? 6'($urandom_range(39, 63)) : 6'($urandom_range(0, 38)));
            n = (ph % 4 == 0) ? 0 : 1;
            for (int i = 0; i < 50; i++) begin
                send_request($urandom_range(0, 1), pick_value(),
                             ($urandom_range(0, 9) == 0) ? 6'($urandom_range(39, 63))
                                                       : 6'($urandom_range(0, 38)),
                             n == 0 && i < 25);
                if (i == 25 && ph == 5)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && fit_sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
